@@ rtl/core/lzbd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lzbd_pkg
// Shared constants and types for the packed bitstream decompressor.
// ----------------------------------------------------------------------------
package lzbd_pkg;

	localparam int unsigned HISTORY_DEPTH_DEF = 4096;
	localparam int unsigned OUT_LANES_DEF     = 16;

	localparam logic [31:0] MAGIC_0 = 32'h5150_4143;
	localparam logic [31:0] MAGIC_1 = 32'h322D_4A4D;
	localparam logic [31:0] MAGIC_2 = 32'h5028_4329;
	localparam logic [31:0] MAGIC_3 = 32'h3139_3839;

	// Token decoder field kinds
	localparam logic [2:0] TK_PREFIX  = 3'd0;
	localparam logic [2:0] TK_LITLEN  = 3'd1;
	localparam logic [2:0] TK_LITBYTE = 3'd2;
	localparam logic [2:0] TK_LONGLEN = 3'd3;
	localparam logic [2:0] TK_OFFSET  = 3'd4;

	// Final status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_MAGIC    = 2'd1;
	localparam logic [1:0] ST_CHECKSUM = 2'd2;
	localparam logic [1:0] ST_LENGTH   = 2'd3;

	// Byte request from decoder to packer
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} byte_req_t;

	// Final request from decoder to packer
	typedef struct packed {
		logic       valid;
		logic [1:0] status;
	} fin_req_t;

endpackage
`default_nettype wire

@@ rtl/core/lzbd_packer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lzbd_packer
// Packs bytes sixteen to an output item (fewer in the final item) and holds it
// in an output register.
module lzbd_packer
	import lzbd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire byte_req_t   byte_req,
	input  wire fin_req_t    fin_req,
	output logic             busy,
	output logic             valid,
	input  wire logic        stall,
	output logic [63:0]      bytes_low,
	output logic [63:0]      bytes_high,
	output logic [4:0]       byte_count,
	output logic             last,
	output logic [1:0]       status
);

	logic [7:0]  lane_q [16];
	logic [3:0]  fill_q;
	logic        valid_q;
	logic [127:0] flat;
	logic [127:0] masked;
	logic [4:0]  cnt_q;
	logic        last_q;
	logic [1:0]  stat_q;
	logic [127:0] data_q;

	// Callers must not send a request while output slot is occupied; no gating
	assign busy = valid_q;

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			flat[i*8 +: 8] = lane_q[i];
			masked[i*8 +: 8] = (4'(i) < fill_q) ? lane_q[i] : 8'h00;
		end
	end

	// Fill lanes
	always_ff @(posedge clk) begin
		if (byte_req.valid) begin
			lane_q[fill_q] <= byte_req.data;
		end
	end

	// Advance fill count and load the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			valid_q <= 1'b0;
			cnt_q   <= '0;
			last_q  <= 1'b0;
			stat_q  <= '0;
		end else begin
			if (valid_q && !stall) begin
				valid_q <= 1'b0;
			end
			if (byte_req.valid) begin
				fill_q <= fill_q + 4'd1;
				if (fill_q == 4'd15) begin
					valid_q <= 1'b1;
					cnt_q   <= 5'd16;
					last_q  <= 1'b0;
					stat_q  <= ST_OK;
				end
			end else if (fin_req.valid) begin
				fill_q  <= '0;
				valid_q <= 1'b1;
				cnt_q   <= {1'b0, fill_q};
				last_q  <= 1'b1;
				stat_q  <= fin_req.status;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_req.valid && fill_q == 4'd15) begin
			data_q <= {byte_req.data, flat[119:0]};
		end else if (fin_req.valid) begin
			data_q <= masked;
		end
	end

	assign valid      = valid_q;
	assign bytes_low  = data_q[63:0];
	assign bytes_high = data_q[127:64];
	assign byte_count = cnt_q;
	assign last       = last_q;
	assign status     = stat_q;

	a_no_req_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !byte_req.valid && !fin_req.valid)
		else $error("request while output slot occupied");
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !last_q |-> cnt_q == 5'd16)
		else $error("non-final item not full");
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		!(byte_req.valid && fin_req.valid))
		else $error("byte and final request together");

endmodule
`default_nettype wire

@@ rtl/core/lz_bitstream_decompressor.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lz_bitstream_decompressor
// LZ77-style bitstream decompressor with a circular history memory.
// ----------------------------------------------------------------------------
// A header word is handled in the cycle that accepts it. A data word is
// accepted, then walked one bit per cycle through the shared field decoder
// while the packer is not busy. A literal byte is written on the cycle of its
// last bit; each byte of a back-copy takes a history read then a write. Ending
// a stream goes through status, then final item, and drops the bits left in
// the word; a bad magic word goes straight to the final item. Each packed
// output item stalls the decoder until it is taken. The decoder is not ready
// while a word is being worked through.
module lz_bitstream_decompressor
	import lzbd_pkg::*;
#(
	parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF
)(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        packed_word_valid,
	output logic             packed_word_stall,
	input  wire logic [31:0] packed_word,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      bytes_low,
	output logic [63:0]      bytes_high,
	output logic [4:0]       byte_count,
	output logic             last,
	output logic [1:0]       status
);

	localparam int unsigned AW = $clog2(HISTORY_DEPTH);
	localparam logic [3:0] LANES_M1 = 4'(OUT_LANES_DEF - 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_BIT  = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_WR   = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	logic [2:0]  st_q;
	logic [2:0]  phase_q;
	logic [31:0] tlen_q, csum_q, bbuf_q, bw_q;
	logic [2:0]  tk_q;
	logic [3:0]  want_q;
	logic [11:0] facc_q;
	logic [8:0]  cnt_q;
	logic [AW-1:0] hpos_q, src_q;
	logic [1:0]  fstat_q;
	// Remaining bits of the current word minus one; wraps to 31 once the word is used up
	logic [4:0]  bits_left_q;
	logic        pbusy;
	logic [7:0]  hist [HISTORY_DEPTH];
	logic [7:0]  rd_q;
	byte_req_t   breq;
	fin_req_t    freq;
	logic        in_acc;
	logic        bit_in;
	logic [11:0] nacc;
	logic [31:0] magic;
	logic        hist_we;
	logic [7:0]  hist_wd;
	logic [31:0] bw_inc;
	logic        done_now;

	assign packed_word_stall = (st_q != S_IDLE);
	assign in_acc = packed_word_valid && !packed_word_stall;
	assign bit_in = bbuf_q[31];
	assign nacc   = {facc_q[10:0], bit_in};
	assign bw_inc = (bw_q == 32'hFFFF_FFFF) ? bw_q : bw_q + 32'd1;
	assign done_now = (bw_inc >= tlen_q);

	always_comb begin
		unique case (phase_q[1:0])
			2'd0:    magic = MAGIC_0;
			2'd1:    magic = MAGIC_1;
			2'd2:    magic = MAGIC_2;
			default: magic = MAGIC_3;
		endcase
	end

	// History memory: one write, one registered read port
	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist[hpos_q] <= hist_wd;
		end
		rd_q <= hist[src_q];
	end

	// Sequencer and shared bit decoder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; phase_q <= '0; tlen_q <= '0; csum_q <= '0;
			bbuf_q <= '0; bw_q <= '0; tk_q <= TK_PREFIX; want_q <= '0;
			facc_q <= '0; cnt_q <= '0; hpos_q <= '0; src_q <= '0;
			fstat_q <= ST_OK; bits_left_q <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (in_acc) begin
						if (phase_q < 3'd4) begin
							if (packed_word != magic) begin
								fstat_q <= ST_MAGIC;
								st_q <= S_FIN;
							end else begin
								phase_q <= phase_q + 3'd1;
							end
						end else if (phase_q == 3'd4) begin
							tlen_q <= packed_word;
							phase_q <= 3'd5;
						end else if (phase_q == 3'd5) begin
							csum_q <= packed_word;
							phase_q <= 3'd6;
						end else begin
							// load a data word and walk its bits, up to 32
							csum_q <= csum_q ^ packed_word;
							bbuf_q <= packed_word;
							bits_left_q <= 5'd31;
							phase_q <= 3'd6;
							st_q <= S_BIT;
						end
					end
				end
				S_BIT: begin
					if (!pbusy) begin
						bbuf_q <= {bbuf_q[30:0], 1'b0};
						bits_left_q <= bits_left_q - 5'd1;
						st_q <= (bits_left_q == 5'd0) ? S_IDLE : S_BIT;
						if (tk_q == TK_PREFIX) begin
							facc_q <= {9'd0, nacc[2:0]};
							want_q <= want_q + 4'd1;
							if (want_q == 4'd1 && nacc[1:0] == 2'b00) begin
								tk_q <= TK_LITLEN; want_q <= 4'd3; facc_q <= '0;
								cnt_q <= 9'd1;
							end else if (want_q == 4'd1 && nacc[1:0] == 2'b01) begin
								tk_q <= TK_OFFSET; want_q <= 4'd8; facc_q <= '0;
								cnt_q <= 9'd2;
							end else if (want_q >= 4'd2) begin
								facc_q <= '0;
								unique case (nacc[2:0])
									3'd4: begin tk_q <= TK_OFFSET; want_q <= 4'd9;
										cnt_q <= 9'd3; end
									3'd5: begin tk_q <= TK_OFFSET; want_q <= 4'd10;
										cnt_q <= 9'd4; end
									3'd6: begin tk_q <= TK_LONGLEN; want_q <= 4'd8; end
									default: begin tk_q <= TK_LITLEN; want_q <= 4'd8;
										cnt_q <= 9'd9; end
								endcase
							end
						end else begin
							facc_q <= nacc;
							want_q <= want_q - 4'd1;
							if (want_q == 4'd1) begin
								facc_q <= '0;
								unique case (tk_q)
									TK_LITLEN: begin
										cnt_q <= cnt_q + 9'(nacc);
										tk_q <= TK_LITBYTE; want_q <= 4'd8;
									end
									TK_LITBYTE: begin
										hpos_q <= hpos_q + AW'(1);
										bw_q <= bw_inc;
										cnt_q <= cnt_q - 9'd1;
										want_q <= 4'd8;
										if (cnt_q == 9'd1) begin
											tk_q <= TK_PREFIX; want_q <= 4'd0;
											if (done_now) st_q <= S_DONE;
										end
									end
									TK_LONGLEN: begin
										cnt_q <= {1'b0, nacc[7:0]} + 9'd3;
										tk_q <= TK_OFFSET; want_q <= 4'd12;
									end
									default: begin
										src_q <= hpos_q - AW'(nacc) - AW'(1);
										tk_q <= TK_PREFIX; want_q <= 4'd0;
										st_q <= S_RD;
									end
								endcase
							end
						end
					end
				end
				S_RD: st_q <= S_WR;
				S_WR: begin
					if (!pbusy) begin
						hpos_q <= hpos_q + AW'(1);
						src_q <= src_q + AW'(1);
						bw_q <= bw_inc;
						cnt_q <= cnt_q - 9'd1;
						if (cnt_q == 9'd1) begin
							st_q <= done_now ? S_DONE
								: (bits_left_q == 5'd31) ? S_IDLE : S_BIT;
						end else begin
							st_q <= S_RD;
						end
					end
				end
				S_DONE: begin
					fstat_q <= (bw_q != tlen_q) ? ST_LENGTH
						: (csum_q != 32'd0) ? ST_CHECKSUM : ST_OK;
					st_q <= S_FIN;
				end
				default: begin
					if (!pbusy) begin
						st_q <= S_IDLE; phase_q <= '0; tlen_q <= '0; csum_q <= '0;
						bw_q <= '0; tk_q <= TK_PREFIX; want_q <= '0; facc_q <= '0;
						cnt_q <= '0;
					end
				end
			endcase
		end
	end

	// Drive history writes, byte requests and the final request
	always_comb begin
		hist_we = 1'b0;
		hist_wd = rd_q;
		breq = '0;
		freq = '0;
		if (st_q == S_BIT && !pbusy && tk_q == TK_LITBYTE && want_q == 4'd1) begin
			hist_we = 1'b1;
			hist_wd = nacc[7:0];
		end else if (st_q == S_WR && !pbusy) begin
			hist_we = 1'b1;
		end
		breq.valid = hist_we;
		breq.data  = hist_wd;
		freq.valid = (st_q == S_FIN) && !pbusy;
		freq.status = fstat_q;
	end

	lzbd_packer u_packer (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_req   (breq),
		.fin_req    (freq),
		.busy       (pbusy),
		.valid      (out_valid),
		.stall      (out_stall),
		.bytes_low  (bytes_low),
		.bytes_high (bytes_high),
		.byte_count (byte_count),
		.last       (last),
		.status     (status)
	);

	a_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		LANES_M1 == 4'd15)
		else $error("lane count");
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_BIT |-> packed_word_stall)
		else $error("ready while decoding");
	a_copy_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_RD |-> cnt_q != 9'd0)
		else $error("empty copy");

endmodule
`default_nettype wire
